// ===== rtl/i2crb_pkg.sv =====
// Shared types and constants for the I2C slave sequencer with reply buffer.
package i2crb_pkg;

	localparam int BUFFER_BYTES_DEF = 64;
	localparam logic [7:0] BUSY_MARK = 8'h01;
	localparam logic [7:0] LEN_LIMIT = 8'd49;
	localparam logic [3:0] CNT_BYTE = 4'd8;
	localparam logic [3:0] CNT_ACK = 4'd1;
	localparam logic [3:0] CNT_NONE = 4'd0;

	typedef enum logic [1:0] {
		REQ_BUS    = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_COMMIT = 2'd2,
		REQ_BUSY   = 2'd3
	} req_t;

	// result beat, packed highest field first
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [3:0] bit_count;
		logic [7:0] shift_out;
		logic       shift_load;
		logic       sda_enable;
	} res_t;

endpackage

// ===== rtl/i2crb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module i2crb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/i2c_slave_with_reply_buffer.sv =====
// I2C slave byte sequencer with a host-filled reply buffer (top level).
//
//  channel | dir | handshake             | content
//  s_axis  | in  | tvalid/tready         | tuser req_type, tdata bus byte and host fields
//  m_axis  | out | tvalid/tready         | tdata drive, load, count and received byte
//  cfg     | in  | cfg_we (no back-pres) | own_address
//
// One beat per cycle unless m_axis stalls; results register in stage 1, then the output register.
// Reply bytes live in a RAM with registered read: stage 0 updates the sequencer
// and issues the read or write, stage 1 picks up the read data.
// Reset clears the sequencer, length byte and read position; the RAM is not swept.
// A stalled result is held in the output register while stage 1 still takes one beat.
module i2c_slave_with_reply_buffer
	import i2crb_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] start_flag, [8:1] shift_in, [14:9] host_index, [22:15] host_byte,
	// [30:23] msg_length, [31] zero
	input  logic [31:0] s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] sda_enable, [1] shift_load, [9:2] shift_out, [13:10] bit_count,
	// [14] rx_valid, [22:15] rx_byte, [23] zero
	output logic [23:0] m_axis_tdata
);

	localparam int AW = $clog2(BUFFER_BYTES);

	typedef enum logic [2:0] {
		ST_IDLE       = 3'd0,
		ST_RX_ADDR    = 3'd1,
		ST_CHECK_ADDR = 3'd2,
		ST_PREP_START = 3'd3,
		ST_RX_DATA    = 3'd4,
		ST_ACK_DATA   = 3'd5,
		ST_TX_BYTE    = 3'd6,
		ST_TAKE_ACK   = 3'd7
	} state_t;

	// input unpack
	logic       start_flag;
	logic [7:0] shift_in;
	logic [5:0] host_index;
	logic [7:0] host_byte;
	logic [7:0] msg_length;
	req_t       req;

	assign start_flag = s_axis_tdata[0];
	assign shift_in   = s_axis_tdata[8:1];
	assign host_index = s_axis_tdata[14:9];
	assign host_byte  = s_axis_tdata[22:15];
	assign msg_length = s_axis_tdata[30:23];
	assign req        = req_t'(s_axis_tuser);

	logic [6:0] own_q;
	state_t     state_q;
	logic       sda_q;
	logic [7:0] len_q;
	logic [6:0] rpos_q;

	logic       v_s1;
	res_t       res_s1;
	logic       ram_sel_s1;
	logic       out_v_q;
	res_t       out_q;
	res_t       res_fwd;

	logic       accept;
	logic       s1_move;

	state_t     st_cur;
	state_t     st_nxt;
	logic       sda_nxt;
	logic [7:0] len_nxt;
	logic [6:0] rpos_nxt;
	res_t       res_nxt;
	logic       ram_sel_nxt;
	logic       ram_we;
	logic       ram_re;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;
	logic [8:0] rpos_w;
	logic [8:0] widx_w;

	assign s1_move       = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || s1_move;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign rpos_w    = {2'b00, rpos_q};
	assign widx_w    = {3'b000, host_index} + 9'd1;
	assign ram_waddr = AW'(widx_w);
	assign ram_raddr = AW'(rpos_w);

	always_comb begin
		st_cur      = start_flag ? ST_RX_ADDR : state_q;
		st_nxt      = state_q;
		sda_nxt     = sda_q;
		len_nxt     = len_q;
		rpos_nxt    = rpos_q;
		res_nxt     = '0;
		ram_sel_nxt = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		case (req)
			REQ_WRITE: begin
				ram_we = accept && (widx_w < 9'(BUFFER_BYTES));
			end
			REQ_COMMIT: begin
				if (msg_length < LEN_LIMIT) begin
					rpos_nxt = '0;
					len_nxt  = msg_length;
				end
			end
			REQ_BUSY: begin
				len_nxt = BUSY_MARK;
			end
			REQ_BUS: begin
				st_nxt = st_cur;
				case (st_cur)
					ST_IDLE: begin
					end
					ST_RX_ADDR: begin
						res_nxt.bit_count = CNT_BYTE;
						st_nxt            = ST_CHECK_ADDR;
					end
					ST_CHECK_ADDR: begin
						if (shift_in[7:1] == own_q) begin
							sda_nxt            = 1'b1;
							res_nxt.shift_load = 1'b1;
							st_nxt             = shift_in[0] ? ST_TX_BYTE : ST_RX_DATA;
						end else begin
							sda_nxt = 1'b0;
							st_nxt  = ST_PREP_START;
						end
						res_nxt.bit_count = CNT_ACK;
					end
					ST_PREP_START: begin
						sda_nxt = 1'b0;
						st_nxt  = ST_IDLE;
					end
					ST_RX_DATA: begin
						sda_nxt           = 1'b0;
						res_nxt.bit_count = CNT_BYTE;
						st_nxt            = ST_ACK_DATA;
					end
					ST_ACK_DATA: begin
						sda_nxt            = 1'b1;
						res_nxt.rx_valid   = 1'b1;
						res_nxt.rx_byte    = shift_in;
						res_nxt.shift_load = 1'b1;
						res_nxt.bit_count  = CNT_ACK;
						st_nxt             = ST_RX_DATA;
					end
					ST_TX_BYTE: begin
						sda_nxt            = 1'b1;
						res_nxt.shift_load = 1'b1;
						res_nxt.bit_count  = CNT_BYTE;
						st_nxt             = ST_TAKE_ACK;
						if (rpos_w >= 9'(BUFFER_BYTES)) begin
							res_nxt.shift_out = '0;
						end else if (len_q == BUSY_MARK) begin
							res_nxt.shift_out = BUSY_MARK;
						end else begin
							if ({1'b0, rpos_q} == len_q) begin
								len_nxt = BUSY_MARK;
							end
							rpos_nxt = rpos_q + 7'd1;
							if (rpos_q == '0) begin
								res_nxt.shift_out = len_nxt;
							end else begin
								ram_sel_nxt = 1'b1;
								ram_re      = accept;
							end
						end
					end
					ST_TAKE_ACK: begin
						sda_nxt           = 1'b0;
						res_nxt.bit_count = CNT_ACK;
						st_nxt            = ST_PREP_START;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		res_nxt.sda_enable = sda_nxt;
	end

	i2crb_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_reply_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(host_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q   <= '0;
			state_q <= ST_IDLE;
			sda_q   <= 1'b0;
			len_q   <= '0;
			rpos_q  <= '0;
		end else begin
			if (cfg_we) begin
				own_q <= cfg_wdata;
			end
			if (accept) begin
				state_q <= st_nxt;
				sda_q   <= sda_nxt;
				len_q   <= len_nxt;
				rpos_q  <= rpos_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_fwd = res_s1;
		if (ram_sel_s1) begin
			res_fwd.shift_out = ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res_nxt;
			ram_sel_s1 <= ram_sel_nxt;
		end
		if (s1_move) begin
			out_q <= res_fwd;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, out_q};

	// committed or busy length never reaches the limit
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q < LEN_LIMIT)
		else $error("length byte out of range");

	// input only stalls when both stages are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && out_v_q))
		else $error("input stalled with a free stage");

	// host beats leave the SDA drive alone
	a_host_sda: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req != REQ_BUS) |=> $stable(sda_q))
		else $error("host beat changed SDA drive");

	// a handed-out byte always comes with an ACK load
	a_rx_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.rx_valid) |->
		(out_q.shift_load && out_q.sda_enable && out_q.bit_count == CNT_ACK))
		else $error("received byte without ACK");

endmodule
